// ----- sv/ssmd_pkg.sv -----
// ssmd_pkg: shared types, command codes and segment encoding for the
// seven-segment multiplexed display driver; no dependencies
package ssmd_pkg;

  // command codes
  localparam logic [1:0] CMD_VOLT    = 2'd0;
  localparam logic [1:0] CMD_AMP     = 2'd1;
  localparam logic [1:0] CMD_POWER   = 2'd2;
  localparam logic [1:0] CMD_REFRESH = 2'd3;

  // scale factors per load command
  localparam logic [13:0] FACTOR_VOLT  = 14'd10;
  localparam logic [13:0] FACTOR_AMP   = 14'd10000;
  localparam logic [13:0] FACTOR_POWER = 14'd100;

  // fixed patterns
  localparam logic [7:0] UNIT_VOLT  = 8'h3E;
  localparam logic [7:0] UNIT_AMP   = 8'h77;
  localparam logic [7:0] UNIT_POWER = 8'h73;
  localparam logic [7:0] DP_BIT     = 8'h80;

  // reciprocal constants for divide by ten
  localparam logic [15:0] RECIP10_W16 = 16'd52429;  // exact for 16-bit values, shift 19
  localparam logic [12:0] RECIP10_W13 = 13'd6554;   // exact for values below 6554, shift 16
  localparam logic [7:0]  RECIP10_W7  = 8'd205;     // exact for values below 128, shift 11

  // serial results per refresh: eight data bits then one latch
  localparam logic [3:0] LATCH_CNT = 4'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic       data_bit;
    logic [3:0] digit_enable_n;
    logic       last;
  } out_item_t;

  // scaled value with its first quotient by ten
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] value;
    logic [12:0] q10;
  } scaled_t;

  // request to the display store / shifter
  typedef struct packed {
    logic            load;
    logic            refresh;
    logic [3:0][7:0] pats;
  } disp_req_t;

  // decimal digit to segment pattern
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/seven_segment_mux_driver.sv -----
// A load passes the scaling and digit registers to the digit store; a refresh takes
// that path to the shifter, which then shows 9 results one per cycle unless stalled.
// Loads 1 per cycle unless a refresh waits on the shifter's latch result being taken.
// Reset (synchronous, active low) blanks all four digits, zeroes the scan position
// and empties the pipeline.
module seven_segment_mux_driver #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssmd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ssmd_pkg::out_item_t out_item
);

  logic                advance;
  logic                sc_valid;
  ssmd_pkg::scaled_t   sc_data;
  logic                req_valid;
  ssmd_pkg::disp_req_t req;
  logic                stall_up;

  // whole pipeline moves unless a refresh waits for the shifter
  assign advance  = !stall_up;
  assign in_stall = stall_up;

  // scaling front end
  ssmd_scale #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .in_valid(in_valid),
    .in_item (in_item),
    .sc_valid(sc_valid),
    .sc_data (sc_data)
  );

  // digit extraction and pattern build
  ssmd_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .sc_valid (sc_valid),
    .sc_data  (sc_data),
    .req_valid(req_valid),
    .req      (req)
  );

  // pattern store and serial output
  ssmd_shifter u_shifter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req      (req),
    .stall_up (stall_up),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// ----- sv/ssmd_scale.sv -----
// ssmd_scale: input register, fixed-point scaling multiply, saturation and
// first divide by ten; depends on ssmd_pkg
module ssmd_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ssmd_pkg::in_item_t in_item,
  output logic               sc_valid,
  output ssmd_pkg::scaled_t  sc_data
);

  localparam int PROD_W = 38;

  logic               v1_r;
  ssmd_pkg::in_item_t item1_r;
  logic               v2_r;
  logic [1:0]         cmd2_r;
  logic [PROD_W-1:0]  prod2_r;
  logic               v3_r;
  ssmd_pkg::scaled_t  sc3_r;

  logic [13:0]        factor;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W-1:0]  shifted;
  logic [15:0]        value;
  logic [31:0]        recip;
  ssmd_pkg::scaled_t  sc3_nxt;

  // factor select and scaling product
  always_comb begin
    case (item1_r.command)
      ssmd_pkg::CMD_VOLT:  factor = ssmd_pkg::FACTOR_VOLT;
      ssmd_pkg::CMD_AMP:   factor = ssmd_pkg::FACTOR_AMP;
      ssmd_pkg::CMD_POWER: factor = ssmd_pkg::FACTOR_POWER;
      default:             factor = '0;
    endcase
    prod_nxt = item1_r.measurement * factor;
  end

  // drop fraction bits, saturate, first quotient by ten
  always_comb begin
    shifted       = prod2_r >> FRACTION_BITS;
    value         = (|shifted[PROD_W-1:16]) ? 16'hFFFF : shifted[15:0];
    recip         = value * ssmd_pkg::RECIP10_W16;
    sc3_nxt.cmd   = cmd2_r;
    sc3_nxt.value = value;
    sc3_nxt.q10   = recip[31:19];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= in_item;
      cmd2_r  <= item1_r.command;
      prod2_r <= prod_nxt;
      sc3_r   <= sc3_nxt;
    end
  end

  assign sc_valid = v3_r;
  assign sc_data  = sc3_r;

endmodule

// ----- sv/ssmd_digits.sv -----
// ssmd_digits: decimal digit extraction by reciprocal multiplies and
// segment pattern assembly per command; depends on ssmd_pkg
module ssmd_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                sc_valid,
  input  ssmd_pkg::scaled_t   sc_data,
  output logic                req_valid,
  output ssmd_pkg::disp_req_t req
);

  logic        v4_r;
  logic [1:0]  cmd4_r;
  logic [3:0]  d0_4_r;
  logic [12:0] q1_4_r;
  logic [9:0]  q2_4_r;

  logic        v5_r;
  logic [1:0]  cmd5_r;
  logic [3:0]  d0_5_r;
  logic [3:0]  d1_5_r;
  logic [9:0]  q2_5_r;
  logic [6:0]  q3_5_r;

  logic [15:0] ten_q1;
  logic [15:0] rem0;
  logic [25:0] p2;
  logic [12:0] ten_q2;
  logic [12:0] rem1;
  logic [22:0] p3;
  logic [9:0]  ten_q3;
  logic [9:0]  rem2;
  logic [14:0] p4;
  logic [3:0]  q4;
  logic [6:0]  ten_q4;
  logic [6:0]  rem3;
  logic [3:0]  d2;
  logic [3:0]  d3;

  // units digit and second quotient
  always_comb begin
    ten_q1 = {sc_data.q10, 3'b000} + {2'b00, sc_data.q10, 1'b0};
    rem0   = sc_data.value - ten_q1;
    p2     = sc_data.q10 * ssmd_pkg::RECIP10_W13;
  end

  // tens digit and third quotient
  always_comb begin
    ten_q2 = {q2_4_r, 3'b000} + {2'b00, q2_4_r, 1'b0};
    rem1   = q1_4_r - ten_q2;
    p3     = q2_4_r * ssmd_pkg::RECIP10_W13;
  end

  // hundreds and thousands digits
  always_comb begin
    ten_q3 = {q3_5_r, 3'b000} + {2'b00, q3_5_r, 1'b0};
    rem2   = q2_5_r - ten_q3;
    d2     = rem2[3:0];
    p4     = q3_5_r * ssmd_pkg::RECIP10_W7;
    q4     = p4[14:11];
    ten_q4 = {q4, 3'b000} + {2'b00, q4, 1'b0};
    rem3   = q3_5_r - ten_q4;
    d3     = rem3[3:0];
  end

  // pattern set per command
  always_comb begin
    req.load    = 1'b1;
    req.refresh = 1'b0;
    req.pats    = '0;
    unique case (cmd5_r)
      ssmd_pkg::CMD_VOLT: begin
        req.pats[0] = ssmd_pkg::seg_of(d2);
        req.pats[1] = ssmd_pkg::seg_of(d1_5_r) | ssmd_pkg::DP_BIT;
        req.pats[2] = ssmd_pkg::seg_of(d0_5_r);
        req.pats[3] = ssmd_pkg::UNIT_VOLT;
      end
      ssmd_pkg::CMD_AMP: begin
        req.pats[0] = ssmd_pkg::seg_of(d3);
        req.pats[1] = ssmd_pkg::seg_of(d2);
        req.pats[2] = ssmd_pkg::seg_of(d1_5_r);
        req.pats[3] = ssmd_pkg::UNIT_AMP;
      end
      ssmd_pkg::CMD_POWER: begin
        req.pats[0] = ssmd_pkg::seg_of(d2) | ssmd_pkg::DP_BIT;
        req.pats[1] = ssmd_pkg::seg_of(d1_5_r);
        req.pats[2] = ssmd_pkg::seg_of(d0_5_r);
        req.pats[3] = ssmd_pkg::UNIT_POWER;
      end
      default: begin
        req.load    = 1'b0;
        req.refresh = 1'b1;
      end
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= sc_valid;
      v5_r <= v4_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      cmd4_r <= sc_data.cmd;
      d0_4_r <= rem0[3:0];
      q1_4_r <= sc_data.q10;
      q2_4_r <= p2[25:16];
      cmd5_r <= cmd4_r;
      d0_5_r <= d0_4_r;
      d1_5_r <= rem1[3:0];
      q2_5_r <= q2_4_r;
      q3_5_r <= p3[22:16];
    end
  end

  assign req_valid = v5_r;

endmodule

// ----- sv/ssmd_shifter.sv -----
// ssmd_shifter: digit pattern store, scan position and serial output of
// one digit per refresh request; depends on ssmd_pkg
module ssmd_shifter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  ssmd_pkg::disp_req_t  req,
  output logic                 stall_up,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssmd_pkg::out_item_t  out_item
);

  logic [3:0][7:0] pat_r;
  logic [1:0]      scan_r;
  logic            active_r;
  logic [3:0]      cnt_r;
  logic [7:0]      shreg_r;
  logic [1:0]      en_pos_r;

  logic            hold;
  logic            take;
  logic            is_latch;

  // busy until the latch result is taken
  assign is_latch = (cnt_r == ssmd_pkg::LATCH_CNT);
  assign hold     = active_r && !(is_latch && !out_stall);
  assign stall_up = req_valid && req.refresh && hold;
  assign take     = req_valid && req.refresh && !hold;

  // pattern store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
    end else if (req_valid && req.load) begin
      pat_r <= req.pats;
    end
  end

  // scan position and shift control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (take) begin
      scan_r   <= scan_r + 2'd1;
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r && !out_stall) begin
      if (is_latch) begin
        active_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  // shift data and latched digit position
  always_ff @(posedge clk) begin
    if (take) begin
      shreg_r  <= pat_r[scan_r];
      en_pos_r <= scan_r;
    end else if (active_r && !out_stall) begin
      shreg_r <= {shreg_r[6:0], 1'b0};
    end
  end

  // result fields
  always_comb begin
    out_item.kind           = is_latch;
    out_item.data_bit       = is_latch ? 1'b0 : shreg_r[7];
    out_item.digit_enable_n = is_latch ? ~(4'b0001 << en_pos_r) : 4'hF;
    out_item.last           = is_latch;
  end

  assign out_valid = active_r;

`ifndef NO_ASSERTIONS
  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stall_up |-> active_r)
    else $error("refresh held back while shifter idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r <= ssmd_pkg::LATCH_CNT))
    else $error("shift count past latch");

  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (active_r && cnt_r == 4'd0))
    else $error("refresh request did not start a run");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (scan_r == $past(scan_r) + 2'd1))
    else $error("scan position did not advance");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && out_stall && !take) |=> (active_r && $stable(cnt_r)))
    else $error("shifter moved while output stalled");
`endif

endmodule

// ----- tb/seven_segment_mux_driver_checker.sv -----
`timescale 1ns / 1ps
// seven_segment_mux_driver_checker: watches both channels of the display driver,
// predicts the shifted segment bits and latch strobes, and counts mismatches
// depends on ssmd_pkg for the request and result types and the command codes
module seven_segment_mux_driver_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ssmd_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ssmd_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  outstanding
);

  // result kinds
  localparam logic KIND_SHIFT = 1'b0;
  localparam logic KIND_LATCH = 1'b1;

  localparam logic [3:0] ALL_DIGITS_OFF = 4'hF;
  localparam logic [15:0] SCALED_MAX = 16'hFFFF;

  // digit to segments, gfedcba
  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // predicted display contents and scan pointer
  logic [7:0] shown_pattern [4];
  logic [1:0] scan_digit;

  // bits and strobes still to come out of the shifter
  ssmd_pkg::out_item_t shift_out_q [$];

  // fixed point reading times factor, truncated and clamped to 16 bits
  function automatic logic [15:0] scale_reading(logic [23:0] meas, logic [13:0] factor);
    logic [37:0] product;
    logic [37:0] whole;
    product = meas * factor;
    whole = product >> FRACTION_BITS;
    return (whole > 38'(SCALED_MAX)) ? SCALED_MAX : whole[15:0];
  endfunction

  // low decimal digit of v as segments
  function automatic logic [7:0] digit_segments(int unsigned v);
    return DIGIT_SEGMENTS[v % 10];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // update the display or queue the bits a refresh shifts out
  task automatic track_request(ssmd_pkg::in_item_t req);
    int unsigned scaled;
    logic [7:0] pattern;
    ssmd_pkg::out_item_t step;
    case (req.command)
      ssmd_pkg::CMD_VOLT: begin
        scaled = 32'(scale_reading(req.measurement, ssmd_pkg::FACTOR_VOLT));
        shown_pattern[0] = digit_segments(scaled / 100);
        shown_pattern[1] = digit_segments(scaled / 10) | ssmd_pkg::DP_BIT;
        shown_pattern[2] = digit_segments(scaled);
        shown_pattern[3] = ssmd_pkg::UNIT_VOLT;
      end
      ssmd_pkg::CMD_AMP: begin
        scaled = 32'(scale_reading(req.measurement, ssmd_pkg::FACTOR_AMP));
        shown_pattern[0] = digit_segments(scaled / 1000);
        shown_pattern[1] = digit_segments(scaled / 100);
        shown_pattern[2] = digit_segments(scaled / 10);
        shown_pattern[3] = ssmd_pkg::UNIT_AMP;
      end
      ssmd_pkg::CMD_POWER: begin
        scaled = 32'(scale_reading(req.measurement, ssmd_pkg::FACTOR_POWER));
        shown_pattern[0] = digit_segments(scaled / 100) | ssmd_pkg::DP_BIT;
        shown_pattern[1] = digit_segments(scaled / 10);
        shown_pattern[2] = digit_segments(scaled);
        shown_pattern[3] = ssmd_pkg::UNIT_POWER;
      end
      ssmd_pkg::CMD_REFRESH: begin
        pattern = shown_pattern[scan_digit];
        // msb first, all digits dark while shifting
        for (int b = 7; b >= 0; b--) begin
          step.kind = KIND_SHIFT;
          step.data_bit = pattern[b];
          step.digit_enable_n = ALL_DIGITS_OFF;
          step.last = 1'b0;
          shift_out_q.push_back(step);
        end
        // latch strobe lights the current digit
        step.kind = KIND_LATCH;
        step.data_bit = 1'b0;
        step.digit_enable_n = ALL_DIGITS_OFF & ~(4'b0001 << scan_digit);
        step.last = 1'b1;
        shift_out_q.push_back(step);
        scan_digit = scan_digit + 2'd1;
      end
    endcase
  endtask

  // compare each accepted result, then fold in each accepted request
  always @(posedge clk) begin : watch
    ssmd_pkg::out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) shown_pattern[k] = 8'h00;
      scan_digit = 2'd0;
      shift_out_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (shift_out_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_item, 0);
        end else begin
          want = shift_out_q.pop_front();
          if (out_item.kind !== want.kind)
            report_mismatch("kind", out_item.kind, want.kind);
          if (out_item.data_bit !== want.data_bit)
            report_mismatch("data_bit", out_item.data_bit, want.data_bit);
          if (out_item.digit_enable_n !== want.digit_enable_n)
            report_mismatch("digit_enable_n", out_item.digit_enable_n, want.digit_enable_n);
          if (out_item.last !== want.last)
            report_mismatch("last", out_item.last, want.last);
        end
      end
      if (in_valid && !in_stall) track_request(in_item);
    end
    outstanding = shift_out_q.size();
  end

endmodule

// ----- tb/seven_segment_mux_driver_test.sv -----
`timescale 1ns / 1ps
// seven_segment_mux_driver_test: drives load and refresh requests into the
// display driver with random idling and back-pressure and reports the verdict
// depends on ssmd_pkg, seven_segment_mux_driver and seven_segment_mux_driver_checker
module seven_segment_mux_driver_test;

  localparam int FRAC_BITS   = 16;
  localparam int ITEM_TARGET = 300;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_BURST  = 30;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int QUIET_FROM  = 240;

  // first current reading that clamps at 65535
  localparam logic [23:0] AMP_CLAMP_EDGE = 24'd429497;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ssmd_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ssmd_pkg::out_item_t out_item;
  int                  fail_count;
  int                  outstanding;

  bit send_gaps = 1'b0;
  bit stall_bursts = 1'b0;
  bit hold_request = 1'b0;
  int sent_count = 0;

  seven_segment_mux_driver #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  seven_segment_mux_driver_checker #(.FRACTION_BITS(FRAC_BITS)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // hard stop
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: one long hold on request, otherwise short random stall bursts
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // offer one request until taken, then maybe idle for a burst
  task automatic send_request(logic [1:0] cmd, logic [23:0] meas);
    ssmd_pkg::in_item_t req;
    req.command = cmd;
    req.measurement = meas;
    in_item <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // stop offering and wait for the shifter to empty, bounded
  task automatic wait_for_drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    @(posedge clk);
  endtask

  // readings spread over the ranges that matter for each unit
  function automatic logic [23:0] pick_reading();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 24'h07FFFF));
      1: return 24'($urandom_range(0, 24'h00FFFF));
      2: return 24'($urandom_range(429480, 429510));
      3: begin
        case ($urandom_range(0, 2))
          0: return 24'h000000;
          1: return 24'hFFFFFF;
          default: return 24'h000001 << $urandom_range(0, 23);
        endcase
      end
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [23:0] noise_bits();
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic refresh_run(int count);
    repeat (count) send_request(ssmd_pkg::CMD_REFRESH, noise_bits());
  endtask

  initial begin
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: blank display at every position first
    refresh_run(4);
    // voltage at full scale, leading digit wraps
    send_request(ssmd_pkg::CMD_VOLT, 24'hFFFFFF);
    refresh_run(4);
    // current 1.2345, leading digit wraps
    send_request(ssmd_pkg::CMD_AMP, 24'd80905);
    refresh_run(4);
    // power 10.0, leading digit wraps
    send_request(ssmd_pkg::CMD_POWER, 24'h0A0000);
    refresh_run(4);
    // current right at the clamp
    send_request(ssmd_pkg::CMD_AMP, AMP_CLAMP_EDGE);
    refresh_run(1);
    // back to back loads, last one wins
    send_request(ssmd_pkg::CMD_VOLT, 24'h000000);
    send_request(ssmd_pkg::CMD_POWER, 24'h000000);
    send_request(ssmd_pkg::CMD_AMP, 24'h000000);
    refresh_run(4);

    // random: mostly a load followed by a few refreshes, some loose requests
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= QUIET_FROM) begin
        send_gaps = 1'b0;
        stall_bursts = 1'b0;
      end else begin
        send_gaps = ((sent_count / 40) % 3) != 2;
        stall_bursts = ((sent_count / 30) % 3) != 1;
      end

      if (!held && sent_count >= 100) begin
        // receiver holds off while refreshes pile up
        held = 1'b1;
        send_gaps = 1'b0;
        hold_request = 1'b1;
        refresh_run(HOLD_BURST);
      end else if (!paused && sent_count >= 200) begin
        paused = 1'b1;
        wait_for_drain();
      end else if ($urandom_range(0, 3) != 0) begin
        send_request(2'($urandom_range(ssmd_pkg::CMD_VOLT, ssmd_pkg::CMD_POWER)),
                     pick_reading());
        refresh_run($urandom_range(1, 5));
      end else begin
        send_request(2'($urandom_range(0, 3)), noise_bits());
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ssmd_pkg.sv
sv/ssmd_scale.sv
sv/ssmd_digits.sv
sv/ssmd_shifter.sv
sv/seven_segment_mux_driver.sv
tb/seven_segment_mux_driver_checker.sv
tb/seven_segment_mux_driver_test.sv
